// ===== hw/rtl/sbce_pkg.sv =====
// ----------------------------------------------------------------------------
// sbce_pkg
// Types, codes and wire store geometry shared by the shared boolean circuit
// evaluator.
// ----------------------------------------------------------------------------
package sbce_pkg;

    localparam int WIRES   = 32768;
    localparam int FIELD_W = 15;
    localparam int WIRE_W  = $clog2(WIRES);
    localparam int ROW_BITS = 8;
    localparam int ROWS    = WIRES / ROW_BITS;
    localparam int ROW_W   = WIRE_W - 3;

    typedef logic [WIRE_W-1:0]   wire_idx_t;
    typedef logic [ROW_W-1:0]    row_idx_t;
    typedef logic [ROW_BITS-1:0] row_data_t;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_GATE = 2'd1,
        OP_PEER = 2'd2,
        OP_READ = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        GATE_AND  = 2'd0,
        GATE_XOR  = 2'd1,
        GATE_NOT  = 2'd2,
        GATE_NOT2 = 2'd3
    } gate_t;

    typedef enum logic [1:0] {
        RES_PAIR  = 2'd0,
        RES_BYTE  = 2'd1,
        RES_ERROR = 2'd2
    } res_kind_t;

    typedef enum logic [1:0] {
        CFG_ROLE     = 2'd0,
        CFG_TRIPLE_A = 2'd1,
        CFG_TRIPLE_B = 2'd2,
        CFG_TRIPLE_C = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         gate_kind;
        logic [FIELD_W-1:0] first_wire;
        logic [FIELD_W-1:0] second_wire;
        logic [FIELD_W-1:0] dest_wire;
        logic               bit_value;
        logic               peer_masked_x;
        logic               peer_masked_y;
    } in_word_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic       send_masked_x;
        logic       send_masked_y;
        logic [7:0] output_byte;
    } out_word_t;

    typedef struct packed {
        logic party_role;
        logic triple_a;
        logic triple_b;
        logic triple_c;
    } cfg_t;

    typedef struct packed {
        logic      rd_en;
        row_idx_t  rd_addr_a;
        row_idx_t  rd_addr_b;
        logic      wr_en;
        row_idx_t  wr_addr;
        row_data_t wr_mask;
        row_data_t wr_data;
    } mem_req_t;

    typedef struct packed {
        row_data_t rd_data_a;
        row_data_t rd_data_b;
    } mem_rsp_t;

    // wire index modulo the store size
    function automatic wire_idx_t wire_idx(logic [FIELD_W-1:0] w);
        wire_idx_t r;
        r = WIRE_W'(w);
        return r;
    endfunction

    function automatic row_idx_t row_of(wire_idx_t w);
        return w[WIRE_W-1:3];
    endfunction

    function automatic logic [2:0] bit_of(wire_idx_t w);
        return w[2:0];
    endfunction

endpackage

// ===== hw/rtl/shared_boolean_circuit_eval_top.sv =====
// ----------------------------------------------------------------------------
// shared_boolean_circuit_eval_top
// One party's evaluator for a secret-shared boolean netlist: wire share
// store, item sequencer, configuration registers and output word register.
// ----------------------------------------------------------------------------
//
//   channel | signals                            | word
//   --------+------------------------------------+-------------------
//   input   | in_valid, in_stall, in_word        | in_word_t
//   output  | out_valid, out_stall, out_word     | out_word_t
//   config  | cfg_wr_en, cfg_index, cfg_data     | one bit per index
//
// every word is a row read of the wire store, then an evaluate and write back;
// a new word is not taken until the last one is through
// a word with a result waits in its evaluate step while the output register
// is full and stalled
// after reset in_stall stays high while the store is cleared one row per
// cycle; config writes are taken at any time
//
module shared_boolean_circuit_eval_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sbce_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output sbce_pkg::out_word_t out_word,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [0:0]          cfg_data
);
    import sbce_pkg::*;

    cfg_t      cfg_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    logic      out_free;
    logic      res_valid;
    out_word_t res_word;
    mem_req_t  mem_req;
    mem_rsp_t  mem_rsp;

    assign out_free = ~out_valid_reg | ~out_stall;

    sbce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .cfg       (cfg_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_word  (res_word),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp)
    );

    sbce_wire_mem u_mem (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROLE:     cfg_reg.party_role <= cfg_data[0];
                CFG_TRIPLE_A: cfg_reg.triple_a   <= cfg_data[0];
                CFG_TRIPLE_B: cfg_reg.triple_b   <= cfg_data[0];
                CFG_TRIPLE_C: cfg_reg.triple_c   <= cfg_data[0];
                default:      cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_word_reg <= res_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== hw/rtl/sbce_wire_mem.sv =====
// ----------------------------------------------------------------------------
// sbce_wire_mem
// Wire share store: rows of eight share bits, two registered read ports and
// one write port with a per-bit write mask.
// ----------------------------------------------------------------------------
module sbce_wire_mem (
    input  logic              clk,
    input  sbce_pkg::mem_req_t req,
    output sbce_pkg::mem_rsp_t rsp
);
    import sbce_pkg::*;

    row_data_t mem [ROWS];
    row_data_t rd_a_reg;
    row_data_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            for (int i = 0; i < ROW_BITS; i++)
            begin
                if (req.wr_mask[i])
                begin
                    mem[req.wr_addr][i] <= req.wr_data[i];
                end
            end
        end
        if (req.rd_en)
        begin
            rd_a_reg <= mem[req.rd_addr_a];
            rd_b_reg <= mem[req.rd_addr_b];
        end
    end

    assign rsp.rd_data_a = rd_a_reg;
    assign rsp.rd_data_b = rd_b_reg;

endmodule

// ===== hw/rtl/sbce_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbce_ctrl
// Item sequencer: clears the store after reset, issues row reads on accept,
// evaluates the item on the read data, then writes a share back or emits a result.
// ----------------------------------------------------------------------------
module sbce_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sbce_pkg::in_word_t  in_word,
    input  sbce_pkg::cfg_t      cfg,
    input  logic                out_free,
    output logic                res_valid,
    output sbce_pkg::out_word_t res_word,
    output sbce_pkg::mem_req_t  mem_req,
    input  sbce_pkg::mem_rsp_t  mem_rsp
);
    import sbce_pkg::*;

    state_t    state_reg, state_next;
    row_idx_t  clr_row_reg;
    in_word_t  item_reg;
    logic      pending_reg, pending_next;
    wire_idx_t pend_dest_reg, pend_dest_next;
    logic      own_x_reg, own_x_next;
    logic      own_y_reg, own_y_next;

    // execute-cycle datapath
    logic       need_res;
    out_word_t  exec_word;
    logic       exec_wr;
    wire_idx_t  exec_wr_wire;
    logic       exec_wr_bit;
    logic       done;
    logic       set_pend;
    logic       clr_pend;

    wire_idx_t        w1, w2, wd, in_w1;
    logic             x, y, d, e, z;
    logic [15:0]      pair_rows;
    logic [7:0]       byte_val;

    assign w1 = wire_idx(item_reg.first_wire);
    assign w2 = wire_idx(item_reg.second_wire);
    assign wd = wire_idx(item_reg.dest_wire);
    assign in_w1 = wire_idx(in_word.first_wire);

    assign x = mem_rsp.rd_data_a[bit_of(w1)];
    assign y = mem_rsp.rd_data_b[bit_of(w2)];
    assign d = own_x_reg ^ item_reg.peer_masked_x;
    assign e = own_y_reg ^ item_reg.peer_masked_y;
    assign z = (d & cfg.triple_b) ^ (e & cfg.triple_a) ^ cfg.triple_c
             ^ (~cfg.party_role & d & e);
    assign pair_rows = {mem_rsp.rd_data_b, mem_rsp.rd_data_a};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_val[7-i] = pair_rows[{1'b0, bit_of(w1)} + 4'(i)];
        end
    end

    always_comb
    begin
        need_res     = 1'b0;
        exec_word    = '0;
        exec_wr      = 1'b0;
        exec_wr_wire = w1;
        exec_wr_bit  = 1'b0;
        set_pend     = 1'b0;
        clr_pend     = 1'b0;
        if (op_t'(item_reg.op) == OP_PEER)
        begin
            if (pending_reg)
            begin
                exec_wr      = 1'b1;
                exec_wr_wire = pend_dest_reg;
                exec_wr_bit  = z;
                clr_pend     = 1'b1;
            end
            else
            begin
                need_res              = 1'b1;
                exec_word.result_kind = RES_ERROR;
            end
        end
        else if (pending_reg)
        begin
            need_res              = 1'b1;
            exec_word.result_kind = RES_ERROR;
        end
        else
        begin
            unique case (op_t'(item_reg.op))
                OP_LOAD:
                begin
                    exec_wr      = 1'b1;
                    exec_wr_wire = w1;
                    exec_wr_bit  = item_reg.bit_value;
                end
                OP_READ:
                begin
                    need_res              = 1'b1;
                    exec_word.result_kind = RES_BYTE;
                    exec_word.output_byte = byte_val;
                end
                OP_GATE:
                begin
                    unique case (gate_t'(item_reg.gate_kind))
                        GATE_AND:
                        begin
                            need_res                = 1'b1;
                            set_pend                = 1'b1;
                            exec_word.result_kind   = RES_PAIR;
                            exec_word.send_masked_x = x ^ cfg.triple_a;
                            exec_word.send_masked_y = y ^ cfg.triple_b;
                        end
                        GATE_XOR:
                        begin
                            exec_wr      = 1'b1;
                            exec_wr_wire = wd;
                            exec_wr_bit  = x ^ y;
                        end
                        GATE_NOT, GATE_NOT2:
                        begin
                            exec_wr      = 1'b1;
                            exec_wr_wire = wd;
                            exec_wr_bit  = x ^ ~cfg.party_role;
                        end
                    endcase
                end
                default:
                begin
                    exec_wr = 1'b0;
                end
            endcase
        end
        done = ~need_res | out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        mem_req        = '0;
        res_valid      = 1'b0;
        res_word       = exec_word;
        in_stall       = 1'b1;
        pending_next   = pending_reg;
        pend_dest_next = pend_dest_reg;
        own_x_next     = own_x_reg;
        own_y_next     = own_y_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_row_reg;
                mem_req.wr_mask = '1;
                mem_req.wr_data = '0;
            end
            ST_IDLE:
            begin
                in_stall          = 1'b0;
                mem_req.rd_en     = in_valid;
                mem_req.rd_addr_a = row_of(in_w1);
                if (op_t'(in_word.op) == OP_READ)
                begin
                    mem_req.rd_addr_b = row_of(in_w1) + ROW_W'(1);
                end
                else
                begin
                    mem_req.rd_addr_b = row_of(wire_idx(in_word.second_wire));
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    res_valid       = need_res;
                    mem_req.wr_en   = exec_wr;
                    mem_req.wr_addr = row_of(exec_wr_wire);
                    mem_req.wr_mask = ROW_BITS'(1) << bit_of(exec_wr_wire);
                    mem_req.wr_data = {ROW_BITS{exec_wr_bit}};
                    if (set_pend)
                    begin
                        pending_next   = 1'b1;
                        pend_dest_next = wd;
                        own_x_next     = exec_word.send_masked_x;
                        own_y_next     = exec_word.send_masked_y;
                    end
                    else if (clr_pend)
                    begin
                        pending_next = 1'b0;
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            pending_reg   <= 1'b0;
            pend_dest_reg <= '0;
            own_x_reg     <= 1'b0;
            own_y_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            pend_dest_reg <= pend_dest_next;
            own_x_reg     <= own_x_next;
            own_y_reg     <= own_y_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            item_reg <= in_word;
        end
    end

endmodule
